// ===== rtl/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg
// Shared constants and types for the stationary interval segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH      = 64;
    localparam int QUEUE_DEPTH      = 4;

    // Queue status seen by the front (full) and the back (empty)
    typedef struct packed {
        logic full;
        logic empty;
    } sis_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/stationary_interval_segmenter.sv =====
// ----------------------------------------------------------------------------
// stationary_interval_segmenter
// Segments stage samples into still intervals with one-sample look-ahead.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle unless in_stall; results leave at one
//   interval per cycle unless out_stall. The front is combinational; an
//   interval is written to the queue when its closing sample transfers,
//   then loaded into the output register, from which it transfers out.
// The four-entry queue absorbs items that close two intervals; the input
//   stalls only while the queue is full.
// Reset: asynchronous, active low, clears all control state; no clearing pass.
`default_nettype none

module stationary_interval_segmenter #(
    parameter int NUMBER_WIDTH = sis_pkg::NUMBER_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [NUMBER_WIDTH-1:0]         sample_number,
    input  wire logic                            moving,
    input  wire logic [sis_pkg::ANGLE_WIDTH-1:0] angle_bits,
    input  wire logic                            end_of_record,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [NUMBER_WIDTH-1:0]              interval_begin,
    output logic [NUMBER_WIDTH-1:0]              interval_end,
    output logic [sis_pkg::ANGLE_WIDTH-1:0]      interval_angle,
    output logic                                 run_last
);
    import sis_pkg::*;

    localparam int EW = 1 + 2 * (2 * NUMBER_WIDTH + ANGLE_WIDTH);

    sis_qstat_t      qstat;
    logic            push, pop;
    logic [EW-1:0]   push_data, pop_data;

    sis_front #(
        .NW (NUMBER_WIDTH),
        .EW (EW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_number (sample_number),
        .moving        (moving),
        .angle_bits    (angle_bits),
        .end_of_record (end_of_record),
        .qstat         (qstat),
        .push          (push),
        .push_data     (push_data)
    );

    sis_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (qstat)
    );

    sis_back #(
        .NW (NUMBER_WIDTH),
        .EW (EW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .qstat          (qstat),
        .pop_data       (pop_data),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .interval_begin (interval_begin),
        .interval_end   (interval_end),
        .interval_angle (interval_angle),
        .run_last       (run_last)
    );

endmodule

`default_nettype wire

// ===== rtl/sis_queue.sv =====
// ----------------------------------------------------------------------------
// sis_queue
// Small register queue between the classifier and the output drain.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  push_data,
    input  wire logic              pop,
    output logic [WIDTH-1:0]       pop_data,
    output sis_pkg::sis_qstat_t    status
);
    import sis_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != FULL_CNT)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/sis_front.sv =====
// ----------------------------------------------------------------------------
// sis_front
// Accepts samples, applies the one-sample look-ahead glitch fix, tracks the
// open still interval and packs the 0..2 intervals an item closes.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_front #(
    parameter int NW = sis_pkg::NUMBER_WIDTH_DEF,
    parameter int EW = 1 + 2 * (2 * NW + sis_pkg::ANGLE_WIDTH)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [NW-1:0]                   sample_number,
    input  wire logic                            moving,
    input  wire logic [sis_pkg::ANGLE_WIDTH-1:0] angle_bits,
    input  wire logic                            end_of_record,
    input  wire sis_pkg::sis_qstat_t             qstat,
    output logic                                 push,
    output logic [EW-1:0]                        push_data
);
    import sis_pkg::*;

    localparam logic [NW-1:0] ONE = NW'(1);

    logic                   held_valid_reg, held_valid_next;
    logic [NW-1:0]          held_number_reg, held_number_next;
    logic                   held_moving_reg, held_moving_next;
    logic [ANGLE_WIDTH-1:0] held_angle_reg, held_angle_next;
    logic                   in_interval_reg, in_interval_next;
    logic [NW-1:0]          open_begin_reg, open_begin_next;
    logic [ANGLE_WIDTH-1:0] open_angle_reg, open_angle_next;

    logic                   accept;
    logic                   held_mov_clean;
    logic                   open_a, close_a;
    logic                   ii1;
    logic [NW-1:0]          begin1;
    logic [ANGLE_WIDTH-1:0] angle1;
    logic                   res_b;
    logic [NW-1:0]          b_begin, b_end;
    logic [ANGLE_WIDTH-1:0] b_angle;
    logic [NW-1:0]          a_end;
    logic [NW-1:0]          r0_begin, r0_end, r1_begin, r1_end;
    logic [ANGLE_WIDTH-1:0] r0_angle, r1_angle;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        // moving glitch: next sample still with identical angle
        held_mov_clean = held_moving_reg && !(!moving && (held_angle_reg == angle_bits));
        open_a  = held_valid_reg && !in_interval_reg && !held_mov_clean;
        close_a = held_valid_reg && in_interval_reg && held_mov_clean;
        a_end   = held_number_reg - ONE;

        ii1    = close_a ? 1'b0 : (open_a ? 1'b1 : in_interval_reg);
        begin1 = open_a ? held_number_reg : open_begin_reg;
        angle1 = open_a ? held_angle_reg : open_angle_reg;

        // final sample: close on moving, otherwise flush through its number
        res_b   = end_of_record && (ii1 || !moving);
        b_begin = ii1 ? begin1 : sample_number;
        b_angle = ii1 ? angle1 : angle_bits;
        b_end   = moving ? (sample_number - ONE) : sample_number;

        if (close_a)
        begin
            r0_begin = open_begin_reg;
            r0_end   = a_end;
            r0_angle = open_angle_reg;
        end
        else
        begin
            r0_begin = b_begin;
            r0_end   = b_end;
            r0_angle = b_angle;
        end
        r1_begin = b_begin;
        r1_end   = b_end;
        r1_angle = b_angle;

        push      = accept && (close_a || res_b);
        push_data = {close_a && res_b, r0_begin, r0_end, r0_angle,
                     r1_begin, r1_end, r1_angle};

        held_valid_next  = held_valid_reg;
        held_number_next = held_number_reg;
        held_moving_next = held_moving_reg;
        held_angle_next  = held_angle_reg;
        in_interval_next = in_interval_reg;
        open_begin_next  = open_begin_reg;
        open_angle_next  = open_angle_reg;
        if (accept)
        begin
            if (end_of_record)
            begin
                held_valid_next  = 1'b0;
                held_number_next = '0;
                held_moving_next = 1'b0;
                held_angle_next  = '0;
                in_interval_next = 1'b0;
                open_begin_next  = '0;
                open_angle_next  = '0;
            end
            else
            begin
                held_valid_next  = 1'b1;
                held_number_next = sample_number;
                held_moving_next = moving;
                held_angle_next  = angle_bits;
                in_interval_next = ii1;
                open_begin_next  = begin1;
                open_angle_next  = angle1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg  <= 1'b0;
            held_number_reg <= '0;
            held_moving_reg <= 1'b0;
            held_angle_reg  <= '0;
            in_interval_reg <= 1'b0;
            open_begin_reg  <= '0;
            open_angle_reg  <= '0;
        end
        else
        begin
            held_valid_reg  <= held_valid_next;
            held_number_reg <= held_number_next;
            held_moving_reg <= held_moving_next;
            held_angle_reg  <= held_angle_next;
            in_interval_reg <= in_interval_next;
            open_begin_reg  <= open_begin_next;
            open_angle_reg  <= open_angle_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sis_back.sv =====
// ----------------------------------------------------------------------------
// sis_back
// Drains queued entries one interval per transfer into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_back #(
    parameter int NW = sis_pkg::NUMBER_WIDTH_DEF,
    parameter int EW = 1 + 2 * (2 * NW + sis_pkg::ANGLE_WIDTH)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sis_pkg::sis_qstat_t         qstat,
    input  wire logic [EW-1:0]               pop_data,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [NW-1:0]                    interval_begin,
    output logic [NW-1:0]                    interval_end,
    output logic [sis_pkg::ANGLE_WIDTH-1:0]  interval_angle,
    output logic                             run_last
);
    import sis_pkg::*;

    logic                   two;
    logic [NW-1:0]          e0_begin, e0_end, e1_begin, e1_end;
    logic [ANGLE_WIDTH-1:0] e0_angle, e1_angle;

    logic                   out_valid_reg, out_valid_next;
    logic                   run_last_reg, run_last_next;
    logic [NW-1:0]          begin_reg, begin_next;
    logic [NW-1:0]          end_reg, end_next;
    logic [ANGLE_WIDTH-1:0] angle_reg, angle_next;
    logic                   pend_reg, pend_next;
    logic [NW-1:0]          pend_begin_reg, pend_begin_next;
    logic [NW-1:0]          pend_end_reg, pend_end_next;
    logic [ANGLE_WIDTH-1:0] pend_angle_reg, pend_angle_next;
    logic                   load_ok;

    assign {two, e0_begin, e0_end, e0_angle, e1_begin, e1_end, e1_angle} = pop_data;

    always_comb
    begin
        load_ok         = !out_valid_reg || !out_stall;
        pop             = load_ok && !pend_reg && !qstat.empty;
        out_valid_next  = out_valid_reg;
        run_last_next   = run_last_reg;
        begin_next      = begin_reg;
        end_next        = end_reg;
        angle_next      = angle_reg;
        pend_next       = pend_reg;
        pend_begin_next = pend_begin_reg;
        pend_end_next   = pend_end_reg;
        pend_angle_next = pend_angle_reg;
        if (load_ok)
        begin
            priority if (pend_reg)
            begin
                out_valid_next = 1'b1;
                run_last_next  = 1'b1;
                begin_next     = pend_begin_reg;
                end_next       = pend_end_reg;
                angle_next     = pend_angle_reg;
                pend_next      = 1'b0;
            end
            else if (!qstat.empty)
            begin
                out_valid_next  = 1'b1;
                run_last_next   = !two;
                begin_next      = e0_begin;
                end_next        = e0_end;
                angle_next      = e0_angle;
                pend_next       = two;
                pend_begin_next = e1_begin;
                pend_end_next   = e1_end;
                pend_angle_next = e1_angle;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_last_reg   <= run_last_next;
        begin_reg      <= begin_next;
        end_reg        <= end_next;
        angle_reg      <= angle_next;
        pend_begin_reg <= pend_begin_next;
        pend_end_reg   <= pend_end_next;
        pend_angle_reg <= pend_angle_next;
    end

    assign out_valid      = out_valid_reg;
    assign run_last       = run_last_reg;
    assign interval_begin = begin_reg;
    assign interval_end   = end_reg;
    assign interval_angle = angle_reg;

    a_pend_has_first: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> out_valid_reg)
        else $error("second interval pending without first on output");

    a_first_needs_pend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !run_last_reg |-> pend_reg)
        else $error("non-final interval shown without its successor pending");

    a_no_pop_on_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !pend_reg && load_ok)
        else $error("queue popped while output busy");

endmodule

`default_nettype wire
